@@ hdl/owpcs_pkg.sv @@
// Shared types and constants for the one-line pulse-width command sender.
// No dependencies; used by owpcs_core and the top level.
`default_nettype none

package owpcs_pkg;

    localparam int unsigned TICK_W = 16;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_REPEAT = 3'd3,
        CMD_VOL_UP = 3'd4,
        CMD_VOL_DN = 3'd5,
        CMD_RESEND = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_VOL_LIMIT = 2'd1,
        ST_TX_BUSY  = 2'd2,
        ST_TICK     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_LONG  = 2'd1,
        CFG_SHORT = 2'd2,
        CFG_TRAIL = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_START = 5'b00010,
        PH_HIGH  = 5'b00100,
        PH_LOW   = 5'b01000,
        PH_TRAIL = 5'b10000
    } t_phase;

    localparam logic [TICK_W-1:0] START_RST = 16'd5000;
    localparam logic [TICK_W-1:0] LONG_RST  = 16'd400;
    localparam logic [TICK_W-1:0] SHORT_RST = 16'd200;
    localparam logic [TICK_W-1:0] TRAIL_RST = 16'd2000;

    localparam logic [7:0] VOL_BASE  = 8'hE0;
    localparam logic [2:0] VOL_TOP   = 3'd7;
    localparam logic [7:0] CODE_STOP = 8'hFE;
    localparam logic [7:0] CODE_REPT = 8'hF2;

    typedef struct packed {
        logic [TICK_W-1:0] start_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] trail_ticks;
    } t_cfg;

    typedef struct packed {
        logic       line_level;
        logic       sending;
        t_status    status;
        logic [2:0] volume_level;
        logic       device_busy;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/owpcs_core.sv @@
// Command decode, volume tracking and frame timing state.
// Depends on owpcs_pkg. Result for an accepted beat is the post-update state.
`default_nettype none

module owpcs_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [2:0]       i_cmd,
    input  wire logic [7:0]       i_playlist,
    input  wire logic             i_busy_pin,
    input  wire owpcs_pkg::t_cfg  i_cfg,
    output owpcs_pkg::t_result    o_result
);

    owpcs_pkg::t_phase  r_phase, n_phase;
    logic [2:0]         r_bit, n_bit;
    logic [owpcs_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [7:0]         r_shift, n_shift;
    logic               r_line, n_line;
    logic [2:0]         r_vol, n_vol;

    owpcs_pkg::t_status status;
    logic               start;
    logic [7:0]         code;
    logic               cur_bit;
    logic [owpcs_pkg::TICK_W-1:0] len_raw, len, tick_inc;

    assign cur_bit = r_shift[r_bit];

    always_comb begin
        unique case (r_phase)
            owpcs_pkg::PH_START: len_raw = i_cfg.start_ticks;
            owpcs_pkg::PH_HIGH:  len_raw = cur_bit ? i_cfg.long_ticks : i_cfg.short_ticks;
            owpcs_pkg::PH_LOW:   len_raw = cur_bit ? i_cfg.short_ticks : i_cfg.long_ticks;
            owpcs_pkg::PH_TRAIL: len_raw = i_cfg.trail_ticks;
            default:             len_raw = owpcs_pkg::TICK_W'(1);
        endcase
        // zero length acts as one tick
        len = (len_raw == '0) ? owpcs_pkg::TICK_W'(1) : len_raw;
    end

    assign tick_inc = r_tick + owpcs_pkg::TICK_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_line  = r_line;
        n_vol   = r_vol;
        status  = owpcs_pkg::ST_TICK;
        start   = 1'b0;
        code    = i_playlist;

        if (i_accept) begin
            if (i_cmd == owpcs_pkg::CMD_TICK || i_cmd > owpcs_pkg::CMD_RESEND) begin
                status = owpcs_pkg::ST_TICK;
                if (r_phase != owpcs_pkg::PH_IDLE) begin
                    if (tick_inc < len) begin
                        n_tick = tick_inc;
                    end else begin
                        n_tick = '0;
                        unique case (r_phase)
                            owpcs_pkg::PH_START: begin
                                n_phase = owpcs_pkg::PH_HIGH;
                                n_bit   = 3'd0;
                                n_line  = 1'b1;
                            end
                            owpcs_pkg::PH_HIGH: begin
                                n_phase = owpcs_pkg::PH_LOW;
                                n_line  = 1'b0;
                            end
                            owpcs_pkg::PH_LOW: begin
                                if (r_bit == 3'd7) begin
                                    n_phase = owpcs_pkg::PH_TRAIL;
                                end else begin
                                    n_bit   = r_bit + 3'd1;
                                    n_phase = owpcs_pkg::PH_HIGH;
                                end
                                n_line = 1'b1;
                            end
                            default: begin
                                n_phase = owpcs_pkg::PH_IDLE;
                                n_line  = 1'b1;
                            end
                        endcase
                    end
                end
            end else if (r_phase != owpcs_pkg::PH_IDLE) begin
                status = owpcs_pkg::ST_TX_BUSY;
            end else begin
                status = owpcs_pkg::ST_ACCEPTED;
                unique case (i_cmd)
                    owpcs_pkg::CMD_PLAY: begin
                        start = 1'b1;
                        code  = i_playlist;
                    end
                    owpcs_pkg::CMD_STOP: begin
                        start = 1'b1;
                        code  = owpcs_pkg::CODE_STOP;
                    end
                    owpcs_pkg::CMD_REPEAT: begin
                        start = 1'b1;
                        code  = owpcs_pkg::CODE_REPT;
                    end
                    owpcs_pkg::CMD_VOL_UP: begin
                        if (r_vol == owpcs_pkg::VOL_TOP) begin
                            status = owpcs_pkg::ST_VOL_LIMIT;
                        end else begin
                            n_vol = r_vol + 3'd1;
                            start = 1'b1;
                            code  = owpcs_pkg::VOL_BASE + 8'(n_vol);
                        end
                    end
                    owpcs_pkg::CMD_VOL_DN: begin
                        if (r_vol == 3'd0) begin
                            status = owpcs_pkg::ST_VOL_LIMIT;
                        end else begin
                            n_vol = r_vol - 3'd1;
                            start = 1'b1;
                            code  = owpcs_pkg::VOL_BASE + 8'(n_vol);
                        end
                    end
                    default: begin
                        start = 1'b1;
                        code  = owpcs_pkg::VOL_BASE + 8'(r_vol);
                    end
                endcase
                if (start) begin
                    n_shift = code;
                    n_bit   = 3'd0;
                    n_tick  = '0;
                    n_phase = owpcs_pkg::PH_START;
                    n_line  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owpcs_pkg::PH_IDLE;
            r_bit   <= 3'd0;
            r_tick  <= '0;
            r_shift <= 8'd0;
            r_line  <= 1'b1;
            r_vol   <= 3'd0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_line  <= n_line;
            r_vol   <= n_vol;
        end
    end

    always_comb begin
        o_result.line_level   = n_line;
        o_result.sending      = (n_phase != owpcs_pkg::PH_IDLE);
        o_result.status       = status;
        o_result.volume_level = n_vol;
        o_result.device_busy  = i_busy_pin;
    end

endmodule

`default_nettype wire

@@ hdl/one_wire_pulse_width_command_sender.sv @@
// One-line pulse-width command sender: config registers, core and result buffer.
// Depends on owpcs_pkg and owpcs_core.
// The result beat of an accepted item is registered in the output register, or in the skid.
// Throughput: one item per cycle while o_in_stall is low; the two-entry result buffer (output
// register plus skid) lets one more item in while a finished beat waits on a stalled output.
// Reset (synchronous, active low): default timings, volume zero, line high, buffer empty.
`default_nettype none

module one_wire_pulse_width_command_sender (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_playlist,
    input  wire logic        i_busy_pin,
    // result channel
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic        o_line_level,
    output      logic        o_sending,
    output      logic [1:0]  o_status,
    output      logic [2:0]  o_volume_level,
    output      logic        o_device_busy
);

    owpcs_pkg::t_cfg    r_cfg;
    owpcs_pkg::t_result new_result;
    owpcs_pkg::t_result r_out, n_out, r_skid, n_skid;
    logic               r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    logic               accept;
    logic               pop;

    // Timing registers: write takes effect on the next tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_ticks <= owpcs_pkg::START_RST;
            r_cfg.long_ticks  <= owpcs_pkg::LONG_RST;
            r_cfg.short_ticks <= owpcs_pkg::SHORT_RST;
            r_cfg.trail_ticks <= owpcs_pkg::TRAIL_RST;
        end else if (i_cfg_we) begin
            unique case (owpcs_pkg::t_cfg_idx'(i_cfg_index))
                owpcs_pkg::CFG_START: r_cfg.start_ticks <= i_cfg_data;
                owpcs_pkg::CFG_LONG:  r_cfg.long_ticks  <= i_cfg_data;
                owpcs_pkg::CFG_SHORT: r_cfg.short_ticks <= i_cfg_data;
                owpcs_pkg::CFG_TRAIL: r_cfg.trail_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall input only when both buffer entries hold beats.
    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign pop        = r_out_valid && !i_out_stall;

    owpcs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_playlist (i_playlist),
        .i_busy_pin (i_busy_pin),
        .i_cfg      (r_cfg),
        .o_result   (new_result)
    );

    // Result buffer: output register in front, skid behind it.
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                // advance skid into the output register, new beat into skid
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = new_result;
                n_skid_valid = accept;
            end else begin
                n_out        = new_result;
                n_out_valid  = accept;
            end
        end else if (accept) begin
            // hold the waiting beat, park the new one
            n_skid       = new_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_level   = r_out.line_level;
    assign o_sending      = r_out.sending;
    assign o_status       = r_out.status;
    assign o_volume_level = r_out.volume_level;
    assign o_device_busy  = r_out.device_busy;

endmodule

`default_nettype wire
